[design/assert_macros.svh]
// Assertion helpers shared by the RTL; every check is clocked on clk and
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[design/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// Types and constants of the environment sensor compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

	// Pressure divider geometry: full 64-bit quotient, divisor magnitude
	// never exceeds 2^30.
	localparam int DIV_W     = 64;
	localparam int DEN_W     = 31;
	localparam int DIV_STEPS = DIV_W;

	localparam logic [31:0]        TEMP_RND       = 32'd128;
	localparam logic signed [32:0] PRESS_TF_OFS   = 33'sd128000;
	localparam logic [20:0]        PRESS_NUM_BASE = 21'd1048576;
	localparam logic [63:0]        PRESS_SCALE    = 64'd3125;
	localparam logic [63:0]        PRESS_V1_BIAS  = 64'h0000_8000_0000_0000;
	localparam logic [31:0]        HUM_TF_OFS     = 32'd76800;
	localparam logic [31:0]        HUM_ACC_MAX    = 32'd419430400;
	localparam logic signed [22:0] HUM_Y_OFS      = 23'sd2097152;
	localparam logic [31:0]        HUM_X_RND      = 32'd16384;
	localparam logic signed [21:0] HUM_Y2_OFS     = 22'sd32768;
	localparam logic [31:0]        HUM_Y_RND      = 32'd8192;

	typedef enum logic [2:0] {
		REG_TEMP     = 3'd0,
		REG_PRESS_LO = 3'd1,
		REG_PRESS_HI = 3'd2,
		REG_PRESS_P9 = 3'd3,
		REG_HUM      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
		logic [15:0] raw_hum;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temp_centideg;
		logic [31:0]        press_q24_8;
		logic               press_div_zero;
		logic [16:0]        hum_q22_10;
	} result_t;

	// Side information riding along with the pressure division.
	typedef struct packed {
		logic [31:0] temp;
		logic [16:0] hum;
		logic        neg;
		logic        div_zero;
	} div_tag_t;

	typedef struct packed {
		logic [DIV_W-1:0] num_mag;
		logic [DEN_W-1:0] den_mag;
		div_tag_t         tag;
	} div_req_t;

	typedef struct packed {
		logic [DIV_W-1:0] quo;
		div_tag_t         tag;
	} div_rsp_t;

endpackage

`default_nettype wire

[design/environment_sensor_compensation_core.sv]
// ----------------------------------------------------------------------------
// environment_sensor_compensation_core
// Integer compensation of raw temperature, pressure and humidity samples.
//   sample channel: one raw triple per transfer (sample_valid/sample_ready).
//   result channel: one compensated triple per transfer (result_valid/ready).
//   cfg port: write cfg_data to coefficient register cfg_index when cfg_we
//   is high; indexes above four are dropped. Write only while idle.
// Throughput is one sample per cycle while the output is not stalled. A
// result passes through 10 stages of temperature, humidity and pressure
// setup, 64 stages of the pressure divider (one quotient bit each) and 6
// stages of pressure finish including the output register.
// The whole pipeline advances together; when the output register holds a
// result the receiver has not taken, every stage holds and sample_ready
// drops in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and the coefficient registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module environment_sensor_compensation_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [63:0]      cfg_data,
	input  wire logic             sample_valid,
	output logic                  sample_ready,
	input  wire esc_pkg::sample_t sample_data,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output esc_pkg::result_t      result_data
);

	// ------------------------------------------------------------------
	// Coefficient registers
	// ------------------------------------------------------------------
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [15:0] press_p9_q;
	logic [63:0] hum_coeffs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_lo_q    <= '0;
			press_hi_q    <= '0;
			press_p9_q    <= '0;
			hum_coeffs_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esc_pkg::REG_TEMP:     temp_coeffs_q <= cfg_data[47:0];
				esc_pkg::REG_PRESS_LO: press_lo_q    <= cfg_data;
				esc_pkg::REG_PRESS_HI: press_hi_q    <= cfg_data;
				esc_pkg::REG_PRESS_P9: press_p9_q    <= cfg_data[15:0];
				esc_pkg::REG_HUM:      hum_coeffs_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack coefficients; the user, not the block, keeps them static in flight.
	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [7:0]         h1, h3;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1 = temp_coeffs_q[15:0];
	assign t2 = $signed(temp_coeffs_q[31:16]);
	assign t3 = $signed(temp_coeffs_q[47:32]);
	assign p1 = press_lo_q[15:0];
	assign p2 = $signed(press_lo_q[31:16]);
	assign p3 = $signed(press_lo_q[47:32]);
	assign p4 = $signed(press_lo_q[63:48]);
	assign p5 = $signed(press_hi_q[15:0]);
	assign p6 = $signed(press_hi_q[31:16]);
	assign p7 = $signed(press_hi_q[47:32]);
	assign p8 = $signed(press_hi_q[63:48]);
	assign p9 = $signed(press_p9_q);
	assign h1 = hum_coeffs_q[7:0];
	assign h2 = $signed(hum_coeffs_q[23:8]);
	assign h3 = hum_coeffs_q[31:24];
	assign h4 = $signed(hum_coeffs_q[43:32]);
	assign h5 = $signed(hum_coeffs_q[55:44]);
	assign h6 = $signed(hum_coeffs_q[63:56]);

	// ------------------------------------------------------------------
	// Pipeline control: advance everything unless the output is stuck.
	// ------------------------------------------------------------------
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s74, vld_s75, vld_s76, vld_s77, vld_s78, vld_s79, vld_s80;

	assign adv          = !vld_s80 || result_ready;
	assign sample_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s75 <= 1'b0;
			vld_s76 <= 1'b0;
			vld_s77 <= 1'b0;
			vld_s78 <= 1'b0;
			vld_s79 <= 1'b0;
			vld_s80 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= sample_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s75 <= vld_s74;
			vld_s76 <= vld_s75;
			vld_s77 <= vld_s76;
			vld_s78 <= vld_s77;
			vld_s79 <= vld_s78;
			vld_s80 <= vld_s79;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: temperature products
	// ------------------------------------------------------------------
	logic signed [18:0] tdiff;
	logic signed [34:0] pa_full;
	logic signed [17:0] dt;
	logic signed [35:0] dd_full;

	assign tdiff   = $signed({2'b00, sample_data.raw_temp[19:3]}) - $signed({2'b00, t1, 1'b0});
	assign pa_full = tdiff * t2;
	assign dt      = $signed({2'b00, sample_data.raw_temp[19:4]}) - $signed({2'b00, t1});
	assign dd_full = dt * dt;

	logic [31:0] pa_s1, dd_s1;
	logic [19:0] press_s1, press_s2, press_s3;
	logic [15:0] hraw_s1, hraw_s2, hraw_s3, hraw_s4;

	// Stage 2: third temperature product
	logic signed [35:0] pb_full;
	assign pb_full = $signed(dd_s1[31:12]) * t3;

	logic signed [20:0] a_s2;
	logic [31:0]        pb_s2;

	// Stage 3: fine temperature
	logic [31:0] tf_s3;

	// Stage 4: temperature result, pressure and humidity offsets
	logic [31:0]        t5, vh;
	logic signed [43:0] h5v_full;
	logic signed [39:0] vh6_full;
	logic signed [40:0] vh3_full;

	assign t5       = {tf_s3[29:0], 2'b00} + tf_s3 + esc_pkg::TEMP_RND;
	assign vh       = tf_s3 - esc_pkg::HUM_TF_OFS;
	assign h5v_full = h5 * $signed(vh);
	assign vh6_full = $signed(vh) * h6;
	assign vh3_full = $signed(vh) * $signed({1'b0, h3});

	logic [31:0]        temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [32:0] v1_s4;
	logic [20:0]        pn_s4, pn_s5, pn_s6, pn_s7;
	logic [31:0]        h5v_s4, vh6_s4, vh3_s4;

	// Stage 5: pressure squares, humidity x term and first y product
	logic signed [65:0] sq_full;
	logic signed [48:0] v5_full, v2p_full;
	logic [31:0]        xsum;
	logic signed [21:0] y2;
	logic signed [43:0] y12_full;

	assign sq_full  = v1_s4 * v1_s4;
	assign v5_full  = v1_s4 * p5;
	assign v2p_full = v1_s4 * p2;
	assign xsum     = {2'b00, hraw_s4, 14'b0} - {h4, 20'b0} - h5v_s4 + esc_pkg::HUM_X_RND;
	assign y2       = $signed({vh3_s4[31], vh3_s4[31:11]}) + esc_pkg::HUM_Y2_OFS;
	assign y12_full = $signed(vh6_s4[31:10]) * y2;

	logic [63:0]        sq_s5;
	logic signed [48:0] v5_s5, v5_s6, v2p_s5, v2p_s6;
	logic signed [16:0] x_s5, x_s6;
	logic [31:0]        y12_s5;

	// Stage 6: pressure 64x16 products, humidity y scaling
	logic signed [79:0] m6_full, m3_full;
	logic signed [22:0] yb;
	logic signed [38:0] yh_full;

	assign m6_full = $signed(sq_s5) * p6;
	assign m3_full = $signed(sq_s5) * p3;
	assign yb      = $signed({y12_s5[31], y12_s5[31:10]}) + esc_pkg::HUM_Y_OFS;
	assign yh_full = yb * h2;

	logic [63:0] m6_s6, m3_s6;
	logic [31:0] yh_s6;

	// Stage 7: pressure sums, humidity x*y
	logic signed [34:0] xy_full;
	assign xy_full = x_s6 * $signed(yh_s6[31:14]);

	logic [63:0] v2_s7, v1b_s7;
	logic [31:0] xy_s7, xy_s8, xy_s9;

	// Stage 8: pressure divisor and dividend base, humidity square
	logic [63:0]        xb;
	logic [79:0]        xp_full;
	logic signed [33:0] sqh_full;

	assign xb       = esc_pkg::PRESS_V1_BIAS + v1b_s7;
	assign xp_full  = xb * p1;
	assign sqh_full = $signed(xy_s7[31:15]) * $signed(xy_s7[31:15]);

	logic [30:0] dv_s8, dv_s9;
	logic [63:0] num0_s8;
	logic [31:0] sqh_s8;

	// Stage 9: dividend scale, humidity correction product
	logic signed [33:0] tt_full;
	assign tt_full = $signed(sqh_s8[31:7]) * $signed({1'b0, h1});

	logic [63:0] num_s9;
	logic [31:0] tt_s9;

	// Stage 10: humidity clamp, divider operands
	logic [31:0] hv, hcl;

	always_comb begin
		hv = xy_s9 - {{4{tt_s9[31]}}, tt_s9[31:4]};
		if (hv[31]) begin
			hcl = '0;
		end else if (hv > esc_pkg::HUM_ACC_MAX) begin
			hcl = esc_pkg::HUM_ACC_MAX;
		end else begin
			hcl = hv;
		end
	end

	esc_pkg::div_req_t req_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			pa_s1    <= pa_full[31:0];
			dd_s1    <= dd_full[31:0];
			press_s1 <= sample_data.raw_press;
			hraw_s1  <= sample_data.raw_hum;
			// stage 2
			a_s2     <= $signed(pa_s1[31:11]);
			pb_s2    <= pb_full[31:0];
			press_s2 <= press_s1;
			hraw_s2  <= hraw_s1;
			// stage 3
			tf_s3    <= {{11{a_s2[20]}}, a_s2} + {{14{pb_s2[31]}}, pb_s2[31:14]};
			press_s3 <= press_s2;
			hraw_s3  <= hraw_s2;
			// stage 4
			temp_s4  <= {{8{t5[31]}}, t5[31:8]};
			v1_s4    <= $signed({tf_s3[31], tf_s3}) - esc_pkg::PRESS_TF_OFS;
			pn_s4    <= esc_pkg::PRESS_NUM_BASE - {1'b0, press_s3};
			h5v_s4   <= h5v_full[31:0];
			vh6_s4   <= vh6_full[31:0];
			vh3_s4   <= vh3_full[31:0];
			hraw_s4  <= hraw_s3;
			// stage 5
			sq_s5    <= sq_full[63:0];
			v5_s5    <= v5_full;
			v2p_s5   <= v2p_full;
			x_s5     <= $signed(xsum[31:15]);
			y12_s5   <= y12_full[31:0];
			temp_s5  <= temp_s4;
			pn_s5    <= pn_s4;
			// stage 6
			m6_s6    <= m6_full[63:0];
			m3_s6    <= m3_full[63:0];
			v5_s6    <= v5_s5;
			v2p_s6   <= v2p_s5;
			x_s6     <= x_s5;
			yh_s6    <= yh_full[31:0] + esc_pkg::HUM_Y_RND;
			temp_s6  <= temp_s5;
			pn_s6    <= pn_s5;
			// stage 7
			v2_s7    <= m6_s6 + ({{15{v5_s6[48]}}, v5_s6} << 17)
				+ ({{48{p4[15]}}, p4} << 35);
			v1b_s7   <= {{8{m3_s6[63]}}, m3_s6[63:8]} + ({{15{v2p_s6[48]}}, v2p_s6} << 12);
			xy_s7    <= xy_full[31:0];
			temp_s7  <= temp_s6;
			pn_s7    <= pn_s6;
			// stage 8
			dv_s8    <= xp_full[63:33];
			num0_s8  <= {12'b0, pn_s7, 31'b0} - v2_s7;
			sqh_s8   <= sqh_full[31:0];
			xy_s8    <= xy_s7;
			temp_s8  <= temp_s7;
			// stage 9
			num_s9   <= num0_s8 * esc_pkg::PRESS_SCALE;
			dv_s9    <= dv_s8;
			tt_s9    <= tt_full[31:0];
			xy_s9    <= xy_s8;
			temp_s9  <= temp_s8;
			// stage 10: take magnitudes, keep the quotient sign aside
			req_s10.num_mag      <= num_s9[63] ? (64'd0 - num_s9) : num_s9;
			req_s10.den_mag      <= dv_s9[30] ? (31'd0 - dv_s9) : dv_s9;
			req_s10.tag.temp     <= temp_s9;
			req_s10.tag.hum      <= hcl[28:12];
			req_s10.tag.neg      <= num_s9[63] ^ dv_s9[30];
			req_s10.tag.div_zero <= (dv_s9 == 31'd0);
		end
	end

	// ------------------------------------------------------------------
	// Stages 11 to 74: pressure division
	// ------------------------------------------------------------------
	esc_pkg::div_rsp_t rsp_s74;

	esc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (vld_s10),
		.req       (req_s10),
		.rsp_valid (vld_s74),
		.rsp       (rsp_s74)
	);

	// ------------------------------------------------------------------
	// Stages 75 to 80: pressure finish and output register
	// ------------------------------------------------------------------
	logic [63:0]        q_s75, q_s76, q_s77, q_s78;
	esc_pkg::div_tag_t  tag_s75, tag_s76, tag_s77, tag_s78, tag_s79;
	logic [63:0]        ps_w;
	logic signed [79:0] m9_full, m8_full;

	assign ps_w    = {{13{q_s75[63]}}, q_s75[63:13]};
	assign m9_full = $signed(ps_w) * p9;
	assign m8_full = $signed(q_s75) * p8;

	logic [63:0] m9_s76, m8_s76, ps_s76;

	// Low 64 bits of m9 * ps from 32-bit partial products.
	logic [63:0] pp0_w;
	logic [31:0] pp1_w, pp2_w;

	assign pp0_w = {32'b0, m9_s76[31:0]} * {32'b0, ps_s76[31:0]};
	assign pp1_w = m9_s76[31:0] * ps_s76[63:32];
	assign pp2_w = m9_s76[63:32] * ps_s76[31:0];

	logic [63:0] pp0_s77, w2_s77, w2_s78, w1_s78, sum_s79;
	logic [31:0] pp1_s77, pp2_s77;
	esc_pkg::result_t result_s80;

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 75: restore the quotient sign
			q_s75   <= rsp_s74.tag.neg ? (64'd0 - rsp_s74.quo) : rsp_s74.quo;
			tag_s75 <= rsp_s74.tag;
			// stage 76
			m9_s76  <= m9_full[63:0];
			m8_s76  <= m8_full[63:0];
			ps_s76  <= ps_w;
			q_s76   <= q_s75;
			tag_s76 <= tag_s75;
			// stage 77
			pp0_s77 <= pp0_w;
			pp1_s77 <= pp1_w;
			pp2_s77 <= pp2_w;
			w2_s77  <= {{19{m8_s76[63]}}, m8_s76[63:19]};
			q_s77   <= q_s76;
			tag_s77 <= tag_s76;
			// stage 78
			w1_s78  <= pp0_s77 + {pp1_s77 + pp2_s77, 32'b0};
			w2_s78  <= w2_s77;
			q_s78   <= q_s77;
			tag_s78 <= tag_s77;
			// stage 79
			sum_s79 <= q_s78 + {{25{w1_s78[63]}}, w1_s78[63:25]} + w2_s78;
			tag_s79 <= tag_s78;
			// stage 80: output register; force zero pressure on a zero divisor
			result_s80.temp_centideg  <= $signed(tag_s79.temp);
			result_s80.press_q24_8    <= tag_s79.div_zero ? 32'd0
				: sum_s79[39:8] + {{12{p7[15]}}, p7, 4'b0000};
			result_s80.press_div_zero <= tag_s79.div_zero;
			result_s80.hum_q22_10     <= tag_s79.hum;
		end
	end

	assign result_valid = vld_s80;
	assign result_data  = result_s80;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_IMPLY(a_divz_press_zero, vld_s80 && result_s80.press_div_zero, result_s80.press_q24_8 == 32'd0, "pressure not zero on zero divisor")
	`ASSERT_IMPLY(a_hum_range, vld_s80, result_s80.hum_q22_10 <= esc_pkg::HUM_ACC_MAX[28:12], "humidity beyond clamp")
	`ASSERT_NEXT(a_div_entry_hold, vld_s10 && !adv, vld_s10 && $stable(req_s10), "divider entry lost during stall")

endmodule

`default_nettype wire

[design/esc_div.sv]
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              req_valid,
	input  wire esc_pkg::div_req_t req,
	output logic                   rsp_valid,
	output esc_pkg::div_rsp_t      rsp
);

	logic [esc_pkg::DIV_STEPS-1:0] vld_s;
	logic [esc_pkg::DIV_W-1:0]     quo_s [esc_pkg::DIV_STEPS];
	logic [esc_pkg::DEN_W-1:0]     rem_s [esc_pkg::DIV_STEPS];
	logic [esc_pkg::DEN_W-1:0]     den_s [esc_pkg::DIV_STEPS];
	esc_pkg::div_tag_t             tag_s [esc_pkg::DIV_STEPS];

	for (genvar k = 0; k < esc_pkg::DIV_STEPS; k++) begin : g_step
		logic                      vld_in;
		logic [esc_pkg::DIV_W-1:0] quo_in;
		logic [esc_pkg::DEN_W-1:0] rem_in;
		logic [esc_pkg::DEN_W-1:0] den_in;
		esc_pkg::div_tag_t         tag_in;
		logic [esc_pkg::DEN_W:0]   trial;
		logic [esc_pkg::DEN_W:0]   diff;
		logic                      fits;

		if (k == 0) begin : g_first
			assign vld_in = req_valid;
			assign quo_in = req.num_mag;
			assign rem_in = '0;
			assign den_in = req.den_mag;
			assign tag_in = req.tag;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign quo_in = quo_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		// Shift in the next dividend bit and try the subtract.
		assign trial = {rem_in, quo_in[esc_pkg::DIV_W-1]};
		assign diff  = trial - {1'b0, den_in};
		assign fits  = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[k] <= {quo_in[esc_pkg::DIV_W-2:0], fits};
				rem_s[k] <= fits ? diff[esc_pkg::DEN_W-1:0] : trial[esc_pkg::DEN_W-1:0];
				den_s[k] <= den_in;
				tag_s[k] <= tag_in;
			end
		end
	end

	assign rsp_valid = vld_s[esc_pkg::DIV_STEPS-1];
	assign rsp.quo   = quo_s[esc_pkg::DIV_STEPS-1];
	assign rsp.tag   = tag_s[esc_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire
